@@ src/dvru_pkg.sv @@
package dvru_pkg;

  localparam int unsigned NODES_DEF = 16;
  localparam int unsigned NID_N     = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned COST_W    = 8;
  localparam int unsigned HOP_W     = 5;
  localparam int unsigned REG_W     = 2;
  localparam int unsigned DATA_W    = 8;

  localparam logic [COST_W-1:0] INF_RESET = 8'd64;
  localparam logic [HOP_W-1:0]  HOP_NONE  = 5'd16;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_ENTRY = 3'd1,
    MODE_LINK  = 3'd2,
    MODE_ADV   = 3'd3,
    MODE_QUERY = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ROUTE = 2'd0,
    KIND_ADV   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ENTRY,
    OP_LINK,
    OP_ADV,
    OP_QUERY
  } op_e;

  typedef enum logic [REG_W-1:0] {
    REG_SELF   = 2'd0,
    REG_INF    = 2'd1,
    REG_POISON = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ID_W-1:0]   node_id;
    logic [ID_W-1:0]   dest_id;
    logic [COST_W-1:0] cost;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   dest_id_res;
    logic [COST_W-1:0] cost_res;
    logic [HOP_W-1:0]  next_hop;
    logic [ID_W-1:0]   target;
    logic              changed;
    logic              last_res;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   dest;
    logic [COST_W-1:0] cost;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   me;
    logic [COST_W-1:0] inf;
    logic              poison;
    logic              clr;
    logic [COST_W-1:0] clr_inf;
  } cfg_t;

  function automatic logic [COST_W-1:0] sat(input logic [COST_W:0] x,
                                            input logic [COST_W-1:0] inf);
    logic [COST_W-1:0] r;
    r = (x >= {1'b0, inf}) ? inf : x[COST_W-1:0];
    return r;
  endfunction

endpackage

@@ src/dvru_queue.sv @@
module dvru_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dvru_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dvru_pkg::cmd_t  cmd_o
);

  dvru_pkg::cmd_t slot_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/dvru_front.sv @@
module dvru_front #(
  parameter int unsigned NODES = dvru_pkg::NODES_DEF
) (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dvru_pkg::in_t  in_i,
  input  dvru_pkg::cfg_t cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output dvru_pkg::cmd_t cmd_o
);

  localparam int unsigned ACT = (NODES < dvru_pkg::NID_N) ? NODES : dvru_pkg::NID_N;

  logic node_ok;
  logic keep;

  // Only checks that do not depend on the route tables are made here.
  assign node_ok = ({1'b0, in_i.node_id} < dvru_pkg::CNT_W'(ACT));

  always_comb begin
    keep   = 1'b0;
    cmd_o  = '{op: dvru_pkg::OP_QUERY, node: in_i.node_id, dest: in_i.dest_id,
               cost: in_i.cost, last: in_i.last};
    case (in_i.mode)
      dvru_pkg::MODE_LOAD: begin
        cmd_o.op = dvru_pkg::OP_LOAD;
        keep     = node_ok && (in_i.node_id != cfg_i.me);
      end
      dvru_pkg::MODE_ENTRY: begin
        cmd_o.op = dvru_pkg::OP_ENTRY;
        keep     = node_ok && (in_i.node_id != cfg_i.me);
      end
      dvru_pkg::MODE_LINK: begin
        cmd_o.op = dvru_pkg::OP_LINK;
        keep     = node_ok;
      end
      dvru_pkg::MODE_ADV: begin
        cmd_o.op = dvru_pkg::OP_ADV;
        keep     = node_ok;
      end
      dvru_pkg::MODE_QUERY: begin
        cmd_o.op = dvru_pkg::OP_QUERY;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

@@ src/dvru_back.sv @@
module dvru_back #(
  parameter int unsigned NODES = dvru_pkg::NODES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dvru_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  dvru_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dvru_pkg::out_t out_o
);

  localparam int unsigned ACT   = (NODES < dvru_pkg::NID_N) ? NODES : dvru_pkg::NID_N;
  localparam int unsigned MEM_D = ACT * dvru_pkg::NID_N;
  localparam int unsigned AW    = $clog2(MEM_D);
  localparam int unsigned CW    = dvru_pkg::CNT_W;
  localparam int unsigned IW    = dvru_pkg::ID_W;
  localparam int unsigned KW    = dvru_pkg::COST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ADV, S_P1_RD, S_P1_CHK, S_P2_START, S_P2_SCAN, S_P2_END, S_DONE
  } state_e;

  state_e             state_q, state_d;
  dvru_pkg::cmd_t     cur_q, cur_d;
  logic [CW-1:0]      d_q, d_d, k_q, k_d;
  logic [KW-1:0]      best_c_q, best_c_d;
  logic [dvru_pkg::HOP_W-1:0] best_q, best_d;
  logic               chg_q, chg_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IW-1:0]      rd_k_q, rd_k_d;
  logic [KW-1:0]      link_q [dvru_pkg::NID_N];
  logic [KW-1:0]      link_d [dvru_pkg::NID_N];
  logic [KW-1:0]      rcost_q [dvru_pkg::NID_N];
  logic [KW-1:0]      rcost_d [dvru_pkg::NID_N];
  logic [dvru_pkg::HOP_W-1:0] rnext_q [dvru_pkg::NID_N];
  logic [dvru_pkg::HOP_W-1:0] rnext_d [dvru_pkg::NID_N];
  logic [MEM_D-1:0]   vld_q, vld_d;
  dvru_pkg::out_t     out_q, out_d;
  logic               ovalid_q, ovalid_d;

  logic [KW-1:0]      mem [MEM_D];
  logic [KW-1:0]      rdat_q;
  logic               rvld_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [KW-1:0]      mem_wdata;

  logic [CW-1:0]      act_c;
  logic               can_emit;
  logic [KW-1:0]      cell_rd;
  logic [IW-1:0]      d_id;
  logic [KW-1:0]      c_sat;
  logic [KW-1:0]      t_val;
  dvru_pkg::out_t     res;

  assign act_c       = CW'(ACT);
  assign can_emit    = !ovalid_q || !out_stall_i;
  assign cell_rd     = rvld_q ? rdat_q : cfg_i.inf;
  assign d_id        = d_q[IW-1:0];
  assign c_sat       = dvru_pkg::sat({1'b0, cur_q.cost}, cfg_i.inf);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  function automatic logic is_nb(input logic [IW-1:0] n);
    return ({1'b0, n} < act_c) && (n != cfg_i.me) && (link_q[n] < cfg_i.inf);
  endfunction

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    d_d       = d_q;
    k_d       = k_q;
    best_c_d  = best_c_q;
    best_d    = best_q;
    chg_d     = chg_q;
    rd_pend_d = rd_pend_q;
    rd_k_d    = rd_k_q;
    link_d    = link_q;
    rcost_d   = rcost_q;
    rnext_d   = rnext_q;
    vld_d     = vld_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q && out_stall_i;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'({cur_q.node, cur_q.dest});
    mem_wdata = c_sat;
    mem_raddr = AW'({cur_q.node, d_id});
    t_val     = dvru_pkg::sat({1'b0, link_q[cur_q.node]} + {1'b0, cell_rd}, cfg_i.inf);
    res       = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cur_q.op)
          dvru_pkg::OP_LOAD: begin
            if (can_emit) begin
              link_d[cur_q.node]  = c_sat;
              rcost_d[cur_q.node] = c_sat;
              rnext_d[cur_q.node] = (c_sat < cfg_i.inf) ? {1'b0, cur_q.node}
                                                         : dvru_pkg::HOP_NONE;
              for (int j = 0; j < dvru_pkg::NID_N; j++) begin
                vld_d[AW'({cur_q.node, IW'(j)})] = 1'b0;
              end
              res.kind        = dvru_pkg::KIND_ROUTE;
              res.dest_id_res = cur_q.node;
              res.cost_res    = c_sat;
              res.next_hop    = rnext_d[cur_q.node];
              res.last_res    = 1'b1;
              out_d    = res;
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
            end
          end
          dvru_pkg::OP_ENTRY: begin
            if ({1'b0, cur_q.dest} < act_c) begin
              mem_we           = 1'b1;
              vld_d[mem_waddr] = 1'b1;
            end
            chg_d   = 1'b0;
            d_d     = '0;
            state_d = cur_q.last ? S_P1_RD : S_IDLE;
          end
          dvru_pkg::OP_LINK: begin
            if (!is_nb(cur_q.node)) begin
              state_d = S_IDLE;
            end else if (rnext_q[cur_q.node] == {1'b0, cur_q.node} &&
                         rcost_q[cur_q.node] != c_sat) begin
              if (can_emit) begin
                link_d[cur_q.node]  = c_sat;
                rcost_d[cur_q.node] = c_sat;
                res.kind        = dvru_pkg::KIND_ROUTE;
                res.dest_id_res = cur_q.node;
                res.cost_res    = c_sat;
                res.next_hop    = {1'b0, cur_q.node};
                out_d    = res;
                ovalid_d = 1'b1;
                chg_d    = 1'b1;
                d_d      = '0;
                state_d  = S_P2_START;
              end
            end else begin
              link_d[cur_q.node] = c_sat;
              chg_d   = 1'b0;
              d_d     = '0;
              state_d = S_P2_START;
            end
          end
          dvru_pkg::OP_ADV: begin
            d_d     = '0;
            state_d = is_nb(cur_q.node) ? S_ADV : S_IDLE;
          end
          dvru_pkg::OP_QUERY: begin
            if (can_emit) begin
              res.kind        = dvru_pkg::KIND_QUERY;
              res.dest_id_res = cur_q.dest;
              res.last_res    = 1'b1;
              res.next_hop    = dvru_pkg::HOP_NONE;
              if ({1'b0, cur_q.dest} >= act_c) begin
                res.cost_res = cfg_i.inf;
              end else if (cur_q.dest != cfg_i.me) begin
                res.cost_res = rcost_q[cur_q.dest];
                res.next_hop = rnext_q[cur_q.dest];
              end
              out_d    = res;
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_ADV: begin
        if (can_emit) begin
          res.kind        = dvru_pkg::KIND_ADV;
          res.dest_id_res = d_id;
          res.cost_res    = (d_id == cfg_i.me) ? '0 : rcost_q[d_id];
          if (cfg_i.poison && rnext_q[d_id] == {1'b0, cur_q.node}) begin
            res.cost_res = cfg_i.inf;
          end
          res.next_hop = rnext_q[d_id];
          res.target   = cur_q.node;
          res.last_res = (d_q == act_c - CW'(1));
          out_d    = res;
          ovalid_d = 1'b1;
          d_d      = d_q + CW'(1);
          if (res.last_res) begin
            state_d = S_IDLE;
          end
        end
      end

      // First pass: refresh routes that go through the sender.
      S_P1_RD: begin
        if (d_q == act_c) begin
          d_d     = '0;
          state_d = S_P2_START;
        end else if (d_id == cfg_i.me || rnext_q[d_id] != {1'b0, cur_q.node}) begin
          d_d = d_q + CW'(1);
        end else begin
          mem_re  = 1'b1;
          state_d = S_P1_CHK;
        end
      end

      S_P1_CHK: begin
        if (rcost_q[d_id] != t_val) begin
          if (can_emit) begin
            rcost_d[d_id]   = t_val;
            res.kind        = dvru_pkg::KIND_ROUTE;
            res.dest_id_res = d_id;
            res.cost_res    = t_val;
            res.next_hop    = {1'b0, cur_q.node};
            out_d    = res;
            ovalid_d = 1'b1;
            chg_d    = 1'b1;
            d_d      = d_q + CW'(1);
            state_d  = S_P1_RD;
          end
        end else begin
          d_d     = d_q + CW'(1);
          state_d = S_P1_RD;
        end
      end

      // Second pass: minimize each destination over all neighbors.
      S_P2_START: begin
        if (d_q == act_c) begin
          state_d = S_DONE;
        end else if (d_id == cfg_i.me) begin
          d_d = d_q + CW'(1);
        end else begin
          best_c_d  = rcost_q[d_id];
          best_d    = dvru_pkg::HOP_NONE;
          k_d       = '0;
          rd_pend_d = 1'b0;
          state_d   = S_P2_SCAN;
        end
      end

      S_P2_SCAN: begin
        if (rd_pend_q) begin
          t_val = dvru_pkg::sat({1'b0, link_q[rd_k_q]} + {1'b0, cell_rd}, cfg_i.inf);
          if (is_nb(rd_k_q) && t_val < best_c_q) begin
            best_c_d = t_val;
            best_d   = {1'b0, rd_k_q};
          end
        end
        if (k_q != act_c) begin
          mem_re    = 1'b1;
          mem_raddr = AW'({k_q[IW-1:0], d_id});
          rd_pend_d = 1'b1;
          rd_k_d    = k_q[IW-1:0];
          k_d       = k_q + CW'(1);
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = S_P2_END;
          end
        end
      end

      S_P2_END: begin
        if (best_q != dvru_pkg::HOP_NONE) begin
          if (can_emit) begin
            rcost_d[d_id]   = best_c_q;
            rnext_d[d_id]   = best_q;
            res.kind        = dvru_pkg::KIND_ROUTE;
            res.dest_id_res = d_id;
            res.cost_res    = best_c_q;
            res.next_hop    = best_q;
            out_d    = res;
            ovalid_d = 1'b1;
            chg_d    = 1'b1;
            d_d      = d_q + CW'(1);
            state_d  = S_P2_START;
          end
        end else begin
          d_d     = d_q + CW'(1);
          state_d = S_P2_START;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          res.kind     = dvru_pkg::KIND_DONE;
          res.changed  = chg_q;
          res.last_res = 1'b1;
          out_d    = res;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // A write of self_id or infinity_cost clears every table, with costs set to the infinity in force.
    if (cfg_i.clr) begin
      vld_d = '0;
      for (int i = 0; i < dvru_pkg::NID_N; i++) begin
        link_d[i]  = cfg_i.clr_inf;
        rcost_d[i] = cfg_i.clr_inf;
        rnext_d[i] = dvru_pkg::HOP_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '{op: dvru_pkg::OP_QUERY, default: '0};
      d_q       <= '0;
      k_q       <= '0;
      best_c_q  <= '0;
      best_q    <= dvru_pkg::HOP_NONE;
      chg_q     <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_k_q    <= '0;
      vld_q     <= '0;
      ovalid_q  <= 1'b0;
      out_q     <= '0;
      rvld_q    <= 1'b0;
      for (int i = 0; i < dvru_pkg::NID_N; i++) begin
        link_q[i]  <= dvru_pkg::INF_RESET;
        rcost_q[i] <= dvru_pkg::INF_RESET;
        rnext_q[i] <= dvru_pkg::HOP_NONE;
      end
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      d_q       <= d_d;
      k_q       <= k_d;
      best_c_q  <= best_c_d;
      best_q    <= best_d;
      chg_q     <= chg_d;
      rd_pend_q <= rd_pend_d;
      rd_k_q    <= rd_k_d;
      vld_q     <= vld_d;
      ovalid_q  <= ovalid_d;
      out_q     <= out_d;
      link_q    <= link_d;
      rcost_q   <= rcost_d;
      rnext_q   <= rnext_d;
      if (mem_re) begin
        rvld_q <= vld_q[mem_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdat_q <= mem[mem_raddr];
    end
  end

endmodule

@@ src/distance_vector_route_update.sv @@
// Channel  Direction  Signals                               Word
// in       input      in_valid_i, in_stall_o, in_i          one command
// out      output     out_valid_o, out_stall_i, out_o       one result
// cfg      input      cfg_we_i, cfg_idx_i, cfg_data_i       one register write
//
// A command that gives no result passes only the idle and execute states of the route
// engine; the length of a recompute is set by the single read port of the neighbor vector
// memory, which is scanned one entry per cycle.
// Reset and writes of self_id or infinity_cost clear all tables at once.
// A two-word queue lets commands arrive while the engine works or the output stalls.
module distance_vector_route_update #(
  parameter int unsigned NODES = dvru_pkg::NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dvru_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dvru_pkg::out_t                out_o,
  input  logic                          cfg_we_i,
  input  logic [dvru_pkg::REG_W-1:0]    cfg_idx_i,
  input  logic [dvru_pkg::DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned ACT = (NODES < dvru_pkg::NID_N) ? NODES : dvru_pkg::NID_N;

  logic [dvru_pkg::ID_W-1:0]   self_q;
  logic [dvru_pkg::COST_W-1:0] inf_q;
  logic                        poison_q;
  dvru_pkg::cfg_t              cfg;
  logic                        push, full, pop, qvalid;
  dvru_pkg::cmd_t              push_cmd, qcmd;

  always_comb begin
    cfg.me      = ({1'b0, self_q} < dvru_pkg::CNT_W'(ACT)) ? self_q : '0;
    cfg.inf     = inf_q;
    cfg.poison  = poison_q;
    cfg.clr     = cfg_we_i && (cfg_idx_i == dvru_pkg::REG_SELF ||
                               cfg_idx_i == dvru_pkg::REG_INF);
    cfg.clr_inf = (cfg_idx_i == dvru_pkg::REG_INF) ? cfg_data_i : inf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= '0;
      inf_q    <= dvru_pkg::INF_RESET;
      poison_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dvru_pkg::REG_SELF:   self_q   <= cfg_data_i[dvru_pkg::ID_W-1:0];
        dvru_pkg::REG_INF:    inf_q    <= cfg_data_i;
        dvru_pkg::REG_POISON: poison_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dvru_front #(.NODES(NODES)) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dvru_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (qvalid),
    .cmd_o      (qcmd)
  );

  dvru_back #(.NODES(NODES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (qvalid),
    .q_cmd_i     (qcmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

@@ src/dvru_checker.sv @@
module dvru_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dvru_pkg::out_t out_o
);

  // A stalled result word stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == dvru_pkg::KIND_DONE |-> out_o.last_res)
    else $error("recompute done word not marked last");

  a_query_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == dvru_pkg::KIND_QUERY |-> out_o.last_res)
    else $error("query answer not marked last");

  // Words other than advert entries and done words leave target and the changed flag at zero.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind != dvru_pkg::KIND_ADV && out_o.kind != dvru_pkg::KIND_DONE
      |-> out_o.target == '0 && !out_o.changed)
    else $error("unused result fields not zero");

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
